FILE: rtl/threefish256_block_cipher_macros.svh
// Assertion macros used by the checker file of the block.
`ifndef THREEFISH256_BLOCK_CIPHER_MACROS_SVH
`define THREEFISH256_BLOCK_CIPHER_MACROS_SVH

// cond implies expr in the same cycle
`define TF_ASSERT_NOW(name, ck, rn, cond, expr) \
    name: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (expr)) \
        else $error("threefish256 check failed");

// cond implies expr in the next cycle
`define TF_ASSERT_NEXT(name, ck, rn, cond, expr) \
    name: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (expr)) \
        else $error("threefish256 check failed");

`endif

FILE: rtl/tf_pkg.sv
// Types, constants and helper functions of the Threefish-256 cipher block.
package tf_pkg;

    localparam int WORD_W      = 64;
    localparam int ROUND_COUNT = 72;
    localparam int KEY_COUNT   = (ROUND_COUNT - 1) / 4 + 2;
    localparam int STEP_COUNT  = ROUND_COUNT + KEY_COUNT;
    localparam int KEY_IDX_W   = $clog2(KEY_COUNT);
    localparam int REG_COUNT   = 6;
    localparam int ADDR_W      = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WORD_W-1:0] KS_PARITY = 64'h1BD11BDAA9FC1A22;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [3:0] block_t;
    typedef word_t [1:0] tweak_t;

    typedef enum logic [2:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_TWEAK0 = 3'd4,
        REG_TWEAK1 = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic                 is_key;
        logic [KEY_IDX_W-1:0] key_idx;
        logic [2:0]           rot_sel;
    } step_t;

    function automatic word_t rotl(input word_t x, input logic [5:0] r);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} << r;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

    function automatic word_t rotr(input word_t x, input logic [5:0] r);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x} >> r;
        return dbl[WORD_W-1:0];
    endfunction

    function automatic logic [5:0] rot_amount(input logic [2:0] sel, input logic half);
        logic [5:0] r;
        case ({sel, half})
            4'd0:    r = 6'd14;
            4'd1:    r = 6'd16;
            4'd2:    r = 6'd52;
            4'd3:    r = 6'd57;
            4'd4:    r = 6'd23;
            4'd5:    r = 6'd40;
            4'd6:    r = 6'd5;
            4'd7:    r = 6'd37;
            4'd8:    r = 6'd25;
            4'd9:    r = 6'd33;
            4'd10:   r = 6'd46;
            4'd11:   r = 6'd12;
            4'd12:   r = 6'd58;
            4'd13:   r = 6'd22;
            4'd14:   r = 6'd32;
            4'd15:   r = 6'd32;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    // Operation at position p of the encryption sequence.
    // Decryption at position p inverts encryption position STEP_COUNT-1-p.
    function automatic step_t enc_step(input int p);
        step_t st;
        int    pos;
        st  = '0;
        pos = 0;
        for (int d = 0; d < ROUND_COUNT; d++)
        begin
            if ((d & 3) == 0)
            begin
                if (pos == p)
                begin
                    st.is_key  = 1'b1;
                    st.key_idx = KEY_IDX_W'(d >> 2);
                end
                pos++;
            end
            if (pos == p)
            begin
                st.is_key  = 1'b0;
                st.rot_sel = 3'(d & 7);
            end
            pos++;
        end
        if (pos == p)
        begin
            st.is_key  = 1'b1;
            st.key_idx = KEY_IDX_W'(KEY_COUNT - 1);
        end
        return st;
    endfunction

endpackage

FILE: rtl/tf_if.sv
// Stream interfaces for input blocks and result blocks.
interface tf_in_if;
    logic          valid;
    logic          ready;
    logic          kind;
    tf_pkg::word_t block_in_0;
    tf_pkg::word_t block_in_1;
    tf_pkg::word_t block_in_2;
    tf_pkg::word_t block_in_3;

    modport source (output valid, kind, block_in_0, block_in_1, block_in_2, block_in_3,
                    input ready);
    modport sink (input valid, kind, block_in_0, block_in_1, block_in_2, block_in_3,
                  output ready);
endinterface

interface tf_out_if;
    logic          valid;
    logic          ready;
    tf_pkg::word_t block_out_0;
    tf_pkg::word_t block_out_1;
    tf_pkg::word_t block_out_2;
    tf_pkg::word_t block_out_3;

    modport source (output valid, block_out_0, block_out_1, block_out_2, block_out_3,
                    input ready);
    modport sink (input valid, block_out_0, block_out_1, block_out_2, block_out_3,
                  output ready);
endinterface

FILE: rtl/tf_key_sched.sv
// Registered subkey table, loaded together with the key and tweak registers.
module tf_key_sched (
    input  logic           clk,
    input  logic           rst_n,
    input  tf_pkg::block_t key,
    input  tf_pkg::tweak_t tweak,
    output tf_pkg::block_t subkey [tf_pkg::KEY_COUNT]
);

    tf_pkg::word_t  k [5];
    tf_pkg::word_t  t [3];
    tf_pkg::block_t subkey_reg [tf_pkg::KEY_COUNT];

    always_comb
    begin
        k[0] = key[0];
        k[1] = key[1];
        k[2] = key[2];
        k[3] = key[3];
        k[4] = tf_pkg::KS_PARITY ^ key[0] ^ key[1] ^ key[2] ^ key[3];
        t[0] = tweak[0];
        t[1] = tweak[1];
        t[2] = tweak[0] ^ tweak[1];
    end

    for (genvar s = 0; s < tf_pkg::KEY_COUNT; s++)
    begin : g_key
        localparam int I0 = s % 5;
        localparam int I1 = (s + 1) % 5;
        localparam int I2 = (s + 2) % 5;
        localparam int I3 = (s + 3) % 5;
        localparam int T1 = s % 3;
        localparam int T2 = (s + 1) % 3;

        // subkey of the all-zero key and tweak
        localparam tf_pkg::word_t R0 = (I0 == 4) ? tf_pkg::KS_PARITY : '0;
        localparam tf_pkg::word_t R1 = (I1 == 4) ? tf_pkg::KS_PARITY : '0;
        localparam tf_pkg::word_t R2 = (I2 == 4) ? tf_pkg::KS_PARITY : '0;
        localparam tf_pkg::word_t R3 = ((I3 == 4) ? tf_pkg::KS_PARITY : '0)
                                       + tf_pkg::word_t'(s);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                subkey_reg[s] <= {R3, R2, R1, R0};
            end
            else
            begin
                subkey_reg[s] <= {k[I3] + tf_pkg::word_t'(s), k[I2] + t[T2],
                                  k[I1] + t[T1], k[I0]};
            end
        end

        assign subkey[s] = subkey_reg[s];
    end

endmodule

FILE: rtl/tf_stage.sv
// One pipeline stage: subkey injection or MIX round, forward or inverse.
module tf_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  tf_pkg::step_t  enc_step,
    input  tf_pkg::step_t  dec_step,
    input  tf_pkg::block_t enc_key,
    input  tf_pkg::block_t dec_key,
    input  logic           valid_in,
    input  logic           kind_in,
    input  tf_pkg::block_t block_in,
    output logic           valid_out,
    output logic           kind_out,
    output tf_pkg::block_t block_out
);

    logic           valid_reg;
    logic           kind_reg;
    tf_pkg::block_t block_reg;
    tf_pkg::block_t enc_res;
    tf_pkg::block_t dec_res;
    tf_pkg::block_t block_next;
    tf_pkg::word_t  a0, a1, b0, b1;
    tf_pkg::word_t  e0, e1, f0, f1;

    always_comb
    begin
        // forward round, then swap words 1 and 3
        a0 = block_in[0] + block_in[1];
        b0 = tf_pkg::rotl(block_in[1], tf_pkg::rot_amount(enc_step.rot_sel, 1'b0)) ^ a0;
        a1 = block_in[2] + block_in[3];
        b1 = tf_pkg::rotl(block_in[3], tf_pkg::rot_amount(enc_step.rot_sel, 1'b1)) ^ a1;
        if (enc_step.is_key)
        begin
            enc_res = {block_in[3] + enc_key[3], block_in[2] + enc_key[2],
                       block_in[1] + enc_key[1], block_in[0] + enc_key[0]};
        end
        else
        begin
            enc_res = {b0, a1, b1, a0};
        end

        // inverse: undo swap, then undo the round
        f0 = tf_pkg::rotr(block_in[3] ^ block_in[0],
                          tf_pkg::rot_amount(dec_step.rot_sel, 1'b0));
        e0 = block_in[0] - f0;
        f1 = tf_pkg::rotr(block_in[1] ^ block_in[2],
                          tf_pkg::rot_amount(dec_step.rot_sel, 1'b1));
        e1 = block_in[2] - f1;
        if (dec_step.is_key)
        begin
            dec_res = {block_in[3] - dec_key[3], block_in[2] - dec_key[2],
                       block_in[1] - dec_key[1], block_in[0] - dec_key[0]};
        end
        else
        begin
            dec_res = {f1, e1, f0, e0};
        end

        block_next = kind_in ? dec_res : enc_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid_in)
        begin
            kind_reg  <= kind_in;
            block_reg <= block_next;
        end
    end

    assign valid_out = valid_reg;
    assign kind_out  = kind_reg;
    assign block_out = block_reg;

endmodule

FILE: rtl/tf_out_queue.sv
// Two-entry result queue that decouples the round pipeline from the sink.
module tf_out_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  tf_pkg::block_t push_block,
    output logic           advance,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tf_pkg::block_t pop_block
);

    logic [tf_pkg::QCNT_W-1:0] count_reg;
    tf_pkg::block_t            head_reg;
    tf_pkg::block_t            tail_reg;
    logic                      push;
    logic                      pop;
    logic                      full;

    assign full      = (count_reg == tf_pkg::QCNT_W'(tf_pkg::QUEUE_DEPTH));
    assign advance   = !full || pop_ready;
    assign push      = advance && push_valid;
    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_block = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push && !pop)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !pop)
        begin
            if (count_reg == '0)
            begin
                head_reg <= push_block;
            end
            else
            begin
                tail_reg <= push_block;
            end
        end
        else if (pop && !push)
        begin
            head_reg <= tail_reg;
        end
        else if (pop && push)
        begin
            if (full)
            begin
                head_reg <= tail_reg;
                tail_reg <= push_block;
            end
            else
            begin
                head_reg <= push_block;
            end
        end
    end

endmodule

FILE: rtl/threefish256_block_cipher.sv
// Threefish-256 block cipher: fully unrolled pipeline, one block per cycle unless
// the result queue is full and the sink is not ready. Each block passes one stage
// per round and per subkey injection (72 + 19 stages), then waits in the result
// queue until the sink takes it; the two-entry queue lets input flow while a result
// waits. Reset clears key and tweak registers, stage valid bits and the queue.
module threefish256_block_cipher (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tf_pkg::ADDR_W-1:0] paddr,
    input  tf_pkg::word_t             pwdata,
    output tf_pkg::word_t             prdata,
    output logic                      pready,
    tf_in_if.sink                     blk_in,
    tf_out_if.source                  blk_out
);

    tf_pkg::block_t   key_reg;
    tf_pkg::block_t   key_next;
    tf_pkg::tweak_t   tweak_reg;
    tf_pkg::tweak_t   tweak_next;
    tf_pkg::reg_idx_t reg_idx;
    logic             cfg_write;
    logic             advance;
    tf_pkg::block_t   subkey [tf_pkg::KEY_COUNT];
    tf_pkg::block_t   result;

    logic           valid_s [tf_pkg::STEP_COUNT+1];
    logic           kind_s  [tf_pkg::STEP_COUNT+1];
    tf_pkg::block_t block_s [tf_pkg::STEP_COUNT+1];

    assign pready    = 1'b1;
    assign reg_idx   = tf_pkg::reg_idx_t'(paddr[tf_pkg::ADDR_W-1:3]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        key_next   = key_reg;
        tweak_next = tweak_reg;
        if (cfg_write)
        begin
            case (reg_idx)
                tf_pkg::REG_KEY0:   key_next[0]   = pwdata;
                tf_pkg::REG_KEY1:   key_next[1]   = pwdata;
                tf_pkg::REG_KEY2:   key_next[2]   = pwdata;
                tf_pkg::REG_KEY3:   key_next[3]   = pwdata;
                tf_pkg::REG_TWEAK0: tweak_next[0] = pwdata;
                tf_pkg::REG_TWEAK1: tweak_next[1] = pwdata;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            tweak_reg <= '0;
        end
        else
        begin
            key_reg   <= key_next;
            tweak_reg <= tweak_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            tf_pkg::REG_KEY0:   prdata = key_reg[0];
            tf_pkg::REG_KEY1:   prdata = key_reg[1];
            tf_pkg::REG_KEY2:   prdata = key_reg[2];
            tf_pkg::REG_KEY3:   prdata = key_reg[3];
            tf_pkg::REG_TWEAK0: prdata = tweak_reg[0];
            tf_pkg::REG_TWEAK1: prdata = tweak_reg[1];
            default:            prdata = '0;
        endcase
    end

    tf_key_sched u_key_sched (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    (key_next),
        .tweak  (tweak_next),
        .subkey (subkey)
    );

    assign blk_in.ready = advance;
    assign valid_s[0]   = blk_in.valid;
    assign kind_s[0]    = blk_in.kind;
    assign block_s[0]   = {blk_in.block_in_3, blk_in.block_in_2,
                           blk_in.block_in_1, blk_in.block_in_0};

    for (genvar p = 0; p < tf_pkg::STEP_COUNT; p++)
    begin : g_stage
        localparam tf_pkg::step_t ENC_STEP = tf_pkg::enc_step(p);
        localparam tf_pkg::step_t DEC_STEP = tf_pkg::enc_step(tf_pkg::STEP_COUNT - 1 - p);

        tf_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .enc_step  (ENC_STEP),
            .dec_step  (DEC_STEP),
            .enc_key   (subkey[ENC_STEP.key_idx]),
            .dec_key   (subkey[DEC_STEP.key_idx]),
            .valid_in  (valid_s[p]),
            .kind_in   (kind_s[p]),
            .block_in  (block_s[p]),
            .valid_out (valid_s[p+1]),
            .kind_out  (kind_s[p+1]),
            .block_out (block_s[p+1])
        );
    end

    tf_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (valid_s[tf_pkg::STEP_COUNT]),
        .push_block (block_s[tf_pkg::STEP_COUNT]),
        .advance    (advance),
        .pop_valid  (blk_out.valid),
        .pop_ready  (blk_out.ready),
        .pop_block  (result)
    );

    assign blk_out.block_out_0 = result[0];
    assign blk_out.block_out_1 = result[1];
    assign blk_out.block_out_2 = result[2];
    assign blk_out.block_out_3 = result[3];

endmodule

FILE: rtl/tf_checker.sv
// Port-level checker for the cipher block and its bind to the top level.
`include "threefish256_block_cipher_macros.svh"

module tf_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      psel,
    input logic                      penable,
    input logic                      pwrite,
    input logic [tf_pkg::ADDR_W-1:0] paddr,
    input tf_pkg::word_t             pwdata,
    input tf_pkg::word_t             prdata,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input tf_pkg::word_t             out_word_0
);

    localparam int CAP   = tf_pkg::STEP_COUNT + tf_pkg::QUEUE_DEPTH;
    localparam int FLT_W = $clog2(CAP + 2);

    logic [FLT_W-1:0] inflight_reg;
    logic             in_xfer;
    logic             out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            inflight_reg <= inflight_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            inflight_reg <= inflight_reg - 1'b1;
        end
    end

    `TF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word_0))
    `TF_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_ready, out_valid)
    `TF_ASSERT_NOW(a_no_phantom_result, clk, rst_n, out_xfer, inflight_reg != '0)
    `TF_ASSERT_NOW(a_capacity, clk, rst_n, 1'b1, inflight_reg <= FLT_W'(CAP))
    `TF_ASSERT_NOW(a_readback, clk, rst_n, $past(psel && penable && pwrite) && paddr == $past(paddr) && paddr[tf_pkg::ADDR_W-1:3] < 3'(tf_pkg::REG_COUNT), prdata == $past(pwdata))

endmodule

bind threefish256_block_cipher tf_checker u_tf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .in_valid   (blk_in.valid),
    .in_ready   (blk_in.ready),
    .out_valid  (blk_out.valid),
    .out_ready  (blk_out.ready),
    .out_word_0 (blk_out.block_out_0)
);
